### rtl/deci_pkg.sv
// shared types and constants of the display escape command interpreter
// no dependencies

package deci_pkg;

  // result action codes
  typedef enum logic [2:0] {
    ACT_SEND  = 3'd0,
    ACT_PIN   = 3'd1,
    ACT_DELAY = 3'd2,
    ACT_END   = 3'd3,
    ACT_ERROR = 3'd4
  } action_e;

  // command codes that follow the escape byte
  localparam logic [7:0] CMD_SLEEP = 8'd1;
  localparam logic [7:0] CMD_CS    = 8'd2;
  localparam logic [7:0] CMD_CMDS  = 8'd3;
  localparam logic [7:0] CMD_RESET = 8'd4;
  localparam logic [7:0] CMD_DATA  = 8'd5;
  localparam logic [7:0] CMD_PIN   = 8'd6;
  localparam logic [7:0] CMD_END   = 8'd7;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_ESC_CODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CS_PIN    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DC_PIN    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RESET_PIN = 2'd3;

  // reset values of the configuration registers
  localparam logic [7:0] ESC_CODE_RST  = 8'd27;
  localparam logic [7:0] CS_PIN_RST    = 8'd0;
  localparam logic [7:0] DC_PIN_RST    = 8'd1;
  localparam logic [7:0] RESET_PIN_RST = 8'd2;

  // one result, lowest field in the lowest bits
  typedef struct packed {
    logic [7:0] delay_ms;
    logic       pin_level;
    logic [7:0] pin_id;
    logic [7:0] out_byte;
    action_e    action;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

  // number of results that follow the first one of a reset pulse
  localparam logic [2:0] RESET_TAIL = 3'd4;

endpackage

### rtl/display_escape_command_interpreter_top.sv
// top level of the display escape command interpreter
// depends on deci_pkg

// usage
// - input stream: one command program byte per transfer on s_axis, tdata holds
//   the byte, tuser marks the first byte of a new program (restarts the parser)
// - output stream: one action per transfer on m_axis, tdata holds action,
//   out_byte, pin_id, pin_level and delay_ms; tlast marks the final result
//   caused by one input byte
// - config: write cfg_data_i to register cfg_idx_i when cfg_we_i is high
//   (escape code, chip select pin, dc pin, reset pin); only while idle
// - path: an accepted byte is held in the input register, and its result is
//   registered into the output register that drives m_axis once that
//   register is free and no reset pulse tail is pending
// - throughput: one byte per cycle while m_axis is ready; the reset command
//   makes five results; a small sequencer plays out its tail of four, one per
//   cycle while m_axis is ready, as the next byte waits in the input register
// - after reset the parser is halted: bytes are dropped until one arrives
//   with the start mark; config registers return to their defaults
// - when m_axis stalls the result is held and one more byte is still taken
//   into the input register, then s_axis_tready_o drops

module display_escape_command_interpreter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] cmd_byte
  input  logic [0:0]                     s_axis_tuser_i,  // [0] start_of_program
  // output stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [2:0] action, [10:3] out_byte, [18:11] pin_id, [19] pin_level,
  // [27:20] delay_ms, rest zero
  output logic [deci_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [deci_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [7:0]                     cfg_data_i
);
  import deci_pkg::*;

  typedef enum logic [3:0] {
    M_HALTED,
    M_PLAIN,
    M_ESC,
    M_SLEEPARG,
    M_CSARG,
    M_RESETARG,
    M_DATALEN,
    M_DATA,
    M_PINID,
    M_PINLVL
  } mode_e;

  // configuration registers
  logic [7:0] esc_code_q, cs_pin_q, dc_pin_q, reset_pin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_code_q  <= ESC_CODE_RST;
      cs_pin_q    <= CS_PIN_RST;
      dc_pin_q    <= DC_PIN_RST;
      reset_pin_q <= RESET_PIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ESC_CODE:  esc_code_q  <= cfg_data_i;
        CFG_CS_PIN:    cs_pin_q    <= cfg_data_i;
        CFG_DC_PIN:    dc_pin_q    <= cfg_data_i;
        CFG_RESET_PIN: reset_pin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // parser state
  mode_e      mode_q, mode_d;
  logic [7:0] data_rem_q, data_rem_d;
  logic [7:0] held_pin_q, held_pin_d;

  // reset pulse sequencer: results still to come and the delay argument
  logic [2:0] seq_cnt_q;
  logic [7:0] seq_arg_q;

  // output register
  logic       out_valid_q;
  result_t    out_res_q;
  logic       out_last_q;

  logic       out_free;
  logic       in_advance;
  logic       s_accept;

  // parser outputs for the byte in the input register
  logic       res_valid;
  result_t    res;
  logic       seq_start;

  // sequencer result
  result_t    seq_res;
  logic       seq_emit;

  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign in_advance = in_valid_q && out_free && (seq_cnt_q == 3'd0);
  assign s_axis_tready_o = !in_valid_q || in_advance;
  assign s_accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign seq_emit   = (seq_cnt_q != 3'd0) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (in_advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i[0];
    end
  end

  // one byte of the parser
  always_comb begin
    mode_e      mode_cur;
    logic [7:0] rem_cur;
    logic [7:0] rem_dec;

    mode_cur   = in_start_q ? M_PLAIN : mode_q;
    rem_cur    = in_start_q ? 8'd0 : data_rem_q;
    rem_dec    = rem_cur - 8'd1;
    mode_d     = mode_cur;
    data_rem_d = rem_cur;
    held_pin_d = held_pin_q;
    res_valid  = 1'b0;
    res        = '0;
    res.action = ACT_SEND;
    seq_start  = 1'b0;

    unique case (mode_cur)
      M_PLAIN: begin
        if (in_byte_q == esc_code_q) begin
          mode_d = M_ESC;
        end else begin
          res_valid    = 1'b1;
          res.out_byte = in_byte_q;
        end
      end
      M_ESC: begin
        mode_d = M_PLAIN;
        // doubled escape wins over a command code of the same value
        if (in_byte_q == esc_code_q) begin
          res_valid    = 1'b1;
          res.out_byte = in_byte_q;
        end else begin
          unique case (in_byte_q)
            CMD_SLEEP: mode_d = M_SLEEPARG;
            CMD_CS:    mode_d = M_CSARG;
            CMD_CMDS: begin
              res_valid  = 1'b1;
              res.action = ACT_PIN;
              res.pin_id = dc_pin_q;
            end
            CMD_RESET: mode_d = M_RESETARG;
            CMD_DATA:  mode_d = M_DATALEN;
            CMD_PIN:   mode_d = M_PINID;
            CMD_END: begin
              res_valid  = 1'b1;
              res.action = ACT_END;
              mode_d     = M_HALTED;
            end
            default: begin
              res_valid  = 1'b1;
              res.action = ACT_ERROR;
              mode_d     = M_HALTED;
            end
          endcase
        end
      end
      M_SLEEPARG: begin
        res_valid    = 1'b1;
        res.action   = ACT_DELAY;
        res.delay_ms = in_byte_q;
        mode_d       = M_PLAIN;
      end
      M_CSARG: begin
        res_valid     = 1'b1;
        res.action    = ACT_PIN;
        res.pin_id    = cs_pin_q;
        res.pin_level = (in_byte_q == 8'd0);
        mode_d        = M_PLAIN;
      end
      M_RESETARG: begin
        // first of five results; the sequencer plays the rest
        res_valid     = 1'b1;
        res.action    = ACT_PIN;
        res.pin_id    = reset_pin_q;
        res.pin_level = 1'b1;
        seq_start     = 1'b1;
        mode_d        = M_PLAIN;
      end
      M_DATALEN: begin
        res_valid     = 1'b1;
        res.action    = ACT_PIN;
        res.pin_id    = dc_pin_q;
        res.pin_level = 1'b1;
        data_rem_d    = in_byte_q;
        mode_d        = (in_byte_q == 8'd0) ? M_PLAIN : M_DATA;
      end
      M_DATA: begin
        res_valid    = 1'b1;
        res.out_byte = in_byte_q;
        data_rem_d   = rem_dec;
        if (rem_dec == 8'd0) begin
          mode_d = M_PLAIN;
        end
      end
      M_PINID: begin
        held_pin_d = in_byte_q;
        mode_d     = M_PINLVL;
      end
      M_PINLVL: begin
        res_valid     = 1'b1;
        res.action    = ACT_PIN;
        res.pin_id    = held_pin_q;
        res.pin_level = (in_byte_q != 8'd0);
        mode_d        = M_PLAIN;
      end
      default: begin
        // halted: byte dropped
        mode_d = M_HALTED;
      end
    endcase
  end

  // tail of the reset pulse: delay, low, delay, high
  always_comb begin
    seq_res = '0;
    if (seq_cnt_q[0]) begin
      seq_res.action    = ACT_PIN;
      seq_res.pin_id    = reset_pin_q;
      seq_res.pin_level = (seq_cnt_q == 3'd1);
    end else begin
      seq_res.action   = ACT_DELAY;
      seq_res.delay_ms = seq_arg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_HALTED;
      data_rem_q <= 8'd0;
      held_pin_q <= 8'd0;
      seq_cnt_q  <= 3'd0;
    end else begin
      if (in_advance) begin
        mode_q     <= mode_d;
        data_rem_q <= data_rem_d;
        held_pin_q <= held_pin_d;
        if (seq_start) begin
          seq_cnt_q <= RESET_TAIL;
        end
      end else if (seq_emit) begin
        seq_cnt_q <= seq_cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_advance && seq_start) begin
      seq_arg_q <= in_byte_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_emit || (in_advance && res_valid)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_emit) begin
      out_res_q  <= seq_res;
      out_last_q <= (seq_cnt_q == 3'd1);
    end else if (in_advance && res_valid) begin
      out_res_q  <= res;
      out_last_q <= !seq_start;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - ResultW){1'b0}}, out_res_q};
  assign m_axis_tlast_o  = out_last_q;

  // the sequencer only runs behind a result it has already placed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_cnt_q != 3'd0) |-> out_valid_q)
    else $error("reset pulse tail pending without a result in the output register");

  // a new byte never overtakes the reset pulse tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_advance && (seq_cnt_q != 3'd0)))
    else $error("parser advanced during the reset pulse tail");

  // the first result of a reset pulse is never marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_advance && seq_start) |=> (out_valid_q && !out_last_q))
    else $error("reset pulse head marked as last");

  // every shown result carries a defined action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.action == ACT_SEND || out_res_q.action == ACT_PIN ||
                     out_res_q.action == ACT_DELAY || out_res_q.action == ACT_END ||
                     out_res_q.action == ACT_ERROR))
    else $error("undefined action on the output");

endmodule

### sim/tb_display_escape_command_interpreter_top.sv
`timescale 1ns / 1ps
// self-checking testbench of display_escape_command_interpreter_top: byte stream in,
// action stream out, checked against an action tracker class; needs deci_pkg and the rtl

module tb_display_escape_command_interpreter_top;
  import deci_pkg::*;

  localparam int unsigned StuckLimit  = 2000; // cycles without any transfer
  localparam int unsigned HoldCycles  = 80;   // long receiver hold-off
  localparam int unsigned SettleCycles = 6;   // input register, output stage, reset tail
  localparam int unsigned PhaseBytes  = 36;   // handled bytes per register setting

  // one byte of a command program as it goes onto the input stream
  typedef struct packed {
    logic       sop;
    logic [7:0] b;
  } prog_byte_t;

  // one expected action, with the end-of-step mark
  typedef struct packed {
    result_t res;
    logic    last;
  } action_rec_t;

  // parser states of the tracker
  typedef enum logic [3:0] {
    P_HALTED, P_PLAIN, P_ESC, P_SLEEP_ARG, P_CS_ARG, P_RESET_ARG,
    P_DATA_LEN, P_DATA, P_PIN_ID, P_PIN_LVL
  } parse_e;

  // receiver stall styles
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_e;

  // ---------------------------------------------------------------------------
  // action tracker: follows the parser byte by byte and holds the actions
  // that the output stream still owes
  // ---------------------------------------------------------------------------
  class display_action_tracker;
    logic [7:0]  esc_code;
    logic [7:0]  cs_pin;
    logic [7:0]  dc_pin;
    logic [7:0]  rst_pin;
    parse_e      mode;
    logic [7:0]  data_left;
    logic [7:0]  held_pin;
    action_rec_t pending[$];
    int unsigned handled, dropped, checked, errors;

    function new();
      esc_code  = ESC_CODE_RST;
      cs_pin    = CS_PIN_RST;
      dc_pin    = DC_PIN_RST;
      rst_pin   = RESET_PIN_RST;
      mode      = P_HALTED;
      data_left = '0;
      held_pin  = '0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [7:0] v);
      case (idx)
        CFG_ESC_CODE: esc_code = v;
        CFG_CS_PIN:   cs_pin   = v;
        CFG_DC_PIN:   dc_pin   = v;
        default:      rst_pin  = v;
      endcase
    endfunction

    function action_rec_t act_rec(action_e a, logic [7:0] ob, logic [7:0] pid, logic lvl,
                                  logic [7:0] dly);
      action_rec_t r;
      r.res.action    = a;
      r.res.out_byte  = ob;
      r.res.pin_id    = pid;
      r.res.pin_level = lvl;
      r.res.delay_ms  = dly;
      r.last          = 1'b0;
      return r;
    endfunction

    // note one accepted input byte and queue the actions it causes
    function void note_byte(logic [7:0] b, logic sop);
      action_rec_t step_q[$];
      if (sop) begin
        mode      = P_PLAIN;
        data_left = '0;
      end
      if (mode == P_HALTED) dropped++;
      else handled++;
      case (mode)
        P_PLAIN: begin
          if (b == esc_code) mode = P_ESC;
          else step_q.push_back(act_rec(ACT_SEND, b, 8'h00, 1'b0, 8'h00));
        end
        P_ESC: begin
          // doubled escape wins over a colliding command code
          if (b == esc_code) begin
            step_q.push_back(act_rec(ACT_SEND, b, 8'h00, 1'b0, 8'h00));
            mode = P_PLAIN;
          end else begin
            case (b)
              CMD_SLEEP: mode = P_SLEEP_ARG;
              CMD_CS:    mode = P_CS_ARG;
              CMD_CMDS: begin
                step_q.push_back(act_rec(ACT_PIN, 8'h00, dc_pin, 1'b0, 8'h00));
                mode = P_PLAIN;
              end
              CMD_RESET: mode = P_RESET_ARG;
              CMD_DATA:  mode = P_DATA_LEN;
              CMD_PIN:   mode = P_PIN_ID;
              CMD_END: begin
                step_q.push_back(act_rec(ACT_END, 8'h00, 8'h00, 1'b0, 8'h00));
                mode = P_HALTED;
              end
              default: begin
                step_q.push_back(act_rec(ACT_ERROR, 8'h00, 8'h00, 1'b0, 8'h00));
                mode = P_HALTED;
              end
            endcase
          end
        end
        P_SLEEP_ARG: begin
          step_q.push_back(act_rec(ACT_DELAY, 8'h00, 8'h00, 1'b0, b));
          mode = P_PLAIN;
        end
        P_CS_ARG: begin
          step_q.push_back(act_rec(ACT_PIN, 8'h00, cs_pin, b == 8'h00, 8'h00));
          mode = P_PLAIN;
        end
        P_RESET_ARG: begin
          step_q.push_back(act_rec(ACT_PIN, 8'h00, rst_pin, 1'b1, 8'h00));
          step_q.push_back(act_rec(ACT_DELAY, 8'h00, 8'h00, 1'b0, b));
          step_q.push_back(act_rec(ACT_PIN, 8'h00, rst_pin, 1'b0, 8'h00));
          step_q.push_back(act_rec(ACT_DELAY, 8'h00, 8'h00, 1'b0, b));
          step_q.push_back(act_rec(ACT_PIN, 8'h00, rst_pin, 1'b1, 8'h00));
          mode = P_PLAIN;
        end
        P_DATA_LEN: begin
          step_q.push_back(act_rec(ACT_PIN, 8'h00, dc_pin, 1'b1, 8'h00));
          data_left = b;
          mode = (b == 8'h00) ? P_PLAIN : P_DATA;
        end
        P_DATA: begin
          step_q.push_back(act_rec(ACT_SEND, b, 8'h00, 1'b0, 8'h00));
          data_left = data_left - 8'd1;
          if (data_left == 8'h00) mode = P_PLAIN;
        end
        P_PIN_ID: begin
          held_pin = b;
          mode = P_PIN_LVL;
        end
        P_PIN_LVL: begin
          step_q.push_back(act_rec(ACT_PIN, 8'h00, held_pin, b != 8'h00, 8'h00));
          mode = P_PLAIN;
        end
        default: mode = P_HALTED;
      endcase
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      foreach (step_q[i]) pending.push_back(step_q[i]);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // compare one output transfer with the oldest owed action
    task check_action(logic [OutDataW-1:0] data, logic last);
      result_t     got;
      action_rec_t want;
      got = result_t'(data[ResultW-1:0]);
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("action with nothing owed, tdata %h", data));
        return;
      end
      want = pending.pop_front();
      if (got.action !== want.res.action)
        report($sformatf("action %0d, want %0d", got.action, want.res.action));
      if (got.out_byte !== want.res.out_byte)
        report($sformatf("out_byte %h, want %h", got.out_byte, want.res.out_byte));
      if (got.pin_id !== want.res.pin_id)
        report($sformatf("pin_id %h, want %h", got.pin_id, want.res.pin_id));
      if (got.pin_level !== want.res.pin_level)
        report($sformatf("pin_level %b, want %b", got.pin_level, want.res.pin_level));
      if (got.delay_ms !== want.res.delay_ms)
        report($sformatf("delay_ms %h, want %h", got.delay_ms, want.res.delay_ms));
      if (last !== want.last)
        report($sformatf("tlast %b, want %b", last, want.last));
      if (data[OutDataW-1:ResultW] !== '0)
        report($sformatf("padding bits not zero, tdata %h", data));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // block ports
  // ---------------------------------------------------------------------------
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i  = '0;  // [7:0] cmd_byte
  logic [0:0]          s_axis_tuser_i  = '0;  // [0] start_of_program
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // [2:0] action, [10:3] out_byte, [18:11] pin_id, [19] pin_level, [27:20] delay_ms
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [7:0]          cfg_data_i      = '0;

  display_escape_command_interpreter_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  display_action_tracker tracker;

  // program under construction, and sender burst state
  prog_byte_t  prog_q[$];
  bit          next_sop    = 1'b0;
  int unsigned burst_left  = 0;

  // receiver state, owned by the receiver process but for hold_toggle, and the watchdog count
  logic        hold_toggle = 1'b0;  // flipped by the main flow to ask for a hold-off
  logic        hold_seen   = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned style_left  = 0;
  int unsigned rx_tick     = 0;
  rx_style_e   rx_style    = RX_OPEN;
  int unsigned stuck_cycles = 0;

  // ---------------------------------------------------------------------------
  // receiver: switches stall styles on its own, and holds tready low for a
  // long stretch when asked
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HoldCycles;
    end
    if (style_left == 0) begin
      style_left = $urandom_range(16, 96);
      rx_style   = rx_style_e'($urandom_range(3));
    end else begin
      style_left--;
    end
    rx_tick++;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (rx_style)
        RX_OPEN:  m_axis_tready_i <= 1'b1;
        RX_LIGHT: m_axis_tready_i <= ($urandom_range(9) != 0);
        RX_HEAVY: m_axis_tready_i <= ($urandom_range(3) == 0);
        default:  m_axis_tready_i <= (rx_tick % 7 < 3);
      endcase
    end
  end

  // output monitor: every transfer is checked against the oldest owed action
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      tracker.check_action(m_axis_tdata_o, m_axis_tlast_o);
  end

  // watchdog: a long run of cycles with no transfer on either side ends the test
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stuck_cycles = 0;
    else if (rst_ni)
      stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("timeout: no transfer for %0d cycles, %0d actions still owed",
               StuckLimit, tracker.pending.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // append one byte; the first byte after next_sop is set carries the start mark
  task automatic add_byte(input logic [7:0] b);
    prog_q.push_back('{sop: next_sop, b: b});
    next_sop = 1'b0;
  endtask

  function automatic logic [7:0] plain_byte(input logic [7:0] esc);
    logic [7:0] v;
    do v = 8'($urandom); while (v == esc);
    return v;
  endfunction

  // one random program: mostly well-formed commands with random arguments,
  // plus restarts in the middle of a command and noise after a halt
  task automatic build_program(input logic [7:0] esc);
    int unsigned kind, n;
    logic [7:0]  v;
    next_sop = 1'b1;
    repeat ($urandom_range(3, 12)) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        repeat ($urandom_range(1, 4)) add_byte(plain_byte(esc));
      end else if (kind < 36) begin
        add_byte(esc);
        add_byte(esc);
      end else if (kind < 43) begin
        add_byte(esc);
        add_byte(CMD_SLEEP);
        add_byte(8'($urandom));
      end else if (kind < 50) begin
        add_byte(esc);
        add_byte(CMD_CS);
        add_byte($urandom_range(1) ? 8'h00 : 8'($urandom));
      end else if (kind < 55) begin
        add_byte(esc);
        add_byte(CMD_CMDS);
      end else if (kind < 61) begin
        add_byte(esc);
        add_byte(CMD_RESET);
        add_byte(8'($urandom));
      end else if (kind < 71) begin
        // raw run, escape bytes inside it included
        n = ($urandom_range(6) == 0) ? 0 : $urandom_range(1, 10);
        add_byte(esc);
        add_byte(CMD_DATA);
        add_byte(8'(n));
        repeat (n) add_byte(($urandom_range(3) == 0) ? esc : 8'($urandom));
      end else if (kind < 80) begin
        add_byte(esc);
        add_byte(CMD_PIN);
        add_byte(8'($urandom));
        add_byte($urandom_range(1) ? 8'h00 : 8'($urandom));
      end else if (kind < 88) begin
        // command cut short by a new start mark
        add_byte(esc);
        if ($urandom_range(1)) add_byte(8'($urandom_range(CMD_SLEEP, CMD_END)));
        next_sop = 1'b1;
      end else begin
        // end or unknown command, then bytes that the halted parser drops
        add_byte(esc);
        if ($urandom_range(1)) begin
          add_byte(CMD_END);
        end else begin
          do v = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
          while ((v inside {[CMD_SLEEP:CMD_END]}) || v == esc);
          add_byte(v);
        end
        repeat ($urandom_range(3)) add_byte(8'($urandom));
        break;
      end
    end
  endtask

  // send the queued program in bursts with random gaps, or without gaps
  task automatic send_program(input bit steady);
    int unsigned gap;
    foreach (prog_q[i]) begin
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= prog_q[i].b;
      s_axis_tuser_i  <= prog_q[i].sop;
      do begin
        @(posedge clk_i);
      end while (!s_axis_tready_o);
      tracker.note_byte(prog_q[i].b, prog_q[i].sop);
      if (!steady) begin
        gap = 0;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap = $urandom_range(8);
        end else begin
          burst_left--;
        end
        if (gap != 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    prog_q.delete();
  endtask

  // sender pause until every owed action has come out and the block is quiet
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // main flow
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned goal;
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the default escape code
    add_byte(8'h41);                       // parser halted after reset: dropped
    next_sop = 1'b1;
    add_byte(8'h00);                       // plain byte extremes
    add_byte(8'hFF);
    add_byte(ESC_CODE_RST);                // doubled escape
    add_byte(ESC_CODE_RST);
    add_byte(ESC_CODE_RST);                // longest sleep
    add_byte(CMD_SLEEP);
    add_byte(8'hFF);
    add_byte(ESC_CODE_RST);                // chip select asserted
    add_byte(CMD_CS);
    add_byte(8'h00);
    add_byte(ESC_CODE_RST);                // command mode
    add_byte(CMD_CMDS);
    add_byte(ESC_CODE_RST);                // reset pulse, five actions
    add_byte(CMD_RESET);
    add_byte(8'h00);
    add_byte(ESC_CODE_RST);                // raw run carrying escape and end codes
    add_byte(CMD_DATA);
    add_byte(8'h02);
    add_byte(ESC_CODE_RST);
    add_byte(CMD_END);
    add_byte(ESC_CODE_RST);                // pin drive, top pin id
    add_byte(CMD_PIN);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(ESC_CODE_RST);                // unknown command halts
    add_byte(8'hFF);
    add_byte(8'h12);                       // dropped while halted
    next_sop = 1'b1;
    add_byte(ESC_CODE_RST);                // start mark in the middle of a sleep
    add_byte(CMD_SLEEP);
    next_sop = 1'b1;
    add_byte(8'h05);
    add_byte(ESC_CODE_RST);                // program end
    add_byte(CMD_END);
    send_program(1'b0);

    // random part, one register setting per phase
    goal = tracker.handled;
    for (int ph = 0; ph <= 4; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin
            write_cfg(CFG_ESC_CODE,  8'h00);
            write_cfg(CFG_CS_PIN,    8'hFF);
            write_cfg(CFG_DC_PIN,    8'h00);
            write_cfg(CFG_RESET_PIN, 8'hFF);
          end
          2: begin
            write_cfg(CFG_ESC_CODE,  8'hFF);
            write_cfg(CFG_CS_PIN,    8'h00);
            write_cfg(CFG_DC_PIN,    8'hFF);
            write_cfg(CFG_RESET_PIN, 8'h00);
          end
          3: begin
            // escape code equal to a command code
            write_cfg(CFG_ESC_CODE,  CMD_CMDS);
            write_cfg(CFG_CS_PIN,    8'($urandom));
            write_cfg(CFG_DC_PIN,    8'($urandom));
            write_cfg(CFG_RESET_PIN, 8'($urandom));
          end
          default: begin
            write_cfg(CFG_ESC_CODE,  8'($urandom));
            write_cfg(CFG_CS_PIN,    8'($urandom));
            write_cfg(CFG_DC_PIN,    8'($urandom));
            write_cfg(CFG_RESET_PIN, 8'($urandom));
          end
        endcase
      end
      if (ph == 1) begin
        // long output hold-off while plain bytes keep coming: block fills up
        hold_toggle <= ~hold_toggle;
        next_sop = 1'b1;
        repeat (30) add_byte(plain_byte(tracker.esc_code));
        send_program(1'b1);
        drain();
      end
      goal += PhaseBytes;
      while (tracker.handled < goal) begin
        build_program(tracker.esc_code);
        send_program(ph == 3);             // one phase without sender gaps
      end
    end

    drain();
    $display("covered %0d program bytes (%0d more dropped while halted), %0d actions checked",
             tracker.handled, tracker.dropped, tracker.checked);
    $display("over 5 register settings incl. extremes and a code collision, one long hold-off");
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
